### rtl/core/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg: shared types and constants of the candidate set hash unit
// Request encoding, back-end states, status codes and SHA-256 constants.
// ----------------------------------------------------------------------------
`default_nettype none

package csd_pkg;

    // one record: family, address high, address low, port
    localparam int REC_W     = 152;
    localparam int REC_BYTES = 19;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // candidate family codes and mapped prefix
    localparam logic [7:0]  FAM_V4      = 8'd4;
    localparam logic [7:0]  FAM_V6      = 8'd6;
    localparam logic [31:0] V4_MAP_WORD = 32'h0000_ffff;
    localparam logic [7:0]  PAD_MARK    = 8'h80;
    localparam logic [5:0]  PAD_STOP    = 6'd56;
    localparam logic [3:0]  LEN_BYTES   = 4'd8;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_BAD,
        CMD_FIN
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [REC_W-1:0]   rec;
    } t_cmd;

    typedef struct packed {
        logic init;
        logic start;
    } t_sha_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_START,
        S_SCAN,
        S_FEED_REC,
        S_PAD_MARK,
        S_PAD_ZERO,
        S_PAD_LEN,
        S_COMP,
        S_DONE,
        S_OUT
    } t_state;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml_s0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_s1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] sha_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

### rtl/core/csd_sha.sv
// ----------------------------------------------------------------------------
// csd_sha: SHA-256 block compressor
// One round per cycle over a 16-word rolling schedule, then a registered
// fold of the working variables into the chaining value.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_sha (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire csd_pkg::t_sha_ctl   i_ctl,
    input  wire logic [511:0]        i_block,
    output logic                     o_busy,
    output logic [255:0]             o_hash
);

    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_rnd;
    logic        r_busy;
    logic        r_add;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;

    // round function and next schedule word
    always_comb begin
        t1 = r_v[7] + csd_pkg::big_s1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + csd_pkg::sha_k(r_rnd) + r_w[0];
        t2 = csd_pkg::big_s0(r_v[0])
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_new = csd_pkg::sml_s1(r_w[14]) + r_w[9] + csd_pkg::sml_s0(r_w[1]) + r_w[0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_add  <= 1'b0;
            r_rnd  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_rnd  <= '0;
        end else if (r_busy) begin
            r_rnd <= r_rnd + 6'd1;
            if (r_rnd == 6'd63) begin
                r_busy <= 1'b0;
                r_add  <= 1'b1;
            end
        end else begin
            r_add <= 1'b0;
        end
    end

    // datapath: load, round, fold
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            for (int i = 0; i < 8; i++) r_h[i] <= csd_pkg::SHA_IV[i];
        end else if (r_add) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
        if (i_ctl.start) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            for (int i = 0; i < 16; i++) r_w[i] <= i_block[511-32*i -: 32];
        end else if (r_busy) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
    end

    assign o_busy = r_busy | r_add;
    assign o_hash = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4], r_h[5], r_h[6], r_h[7]};

endmodule

`default_nettype wire

### rtl/core/csd_front.sv
// ----------------------------------------------------------------------------
// csd_front: request intake and classification
// Validates each candidate, packs it as a record and queues the request in
// a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic            i_action,
    input  wire logic [7:0]      i_family,
    input  wire logic [63:0]     i_addr_hi,
    input  wire logic [63:0]     i_addr_lo,
    input  wire logic [15:0]     i_port,
    output logic                 o_cmd_vld,
    output csd_pkg::t_cmd        o_cmd,
    input  wire logic            i_pop
);

    csd_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    logic          push;
    logic          mapped;
    logic          cand_ok;
    csd_pkg::t_cmd cmd;

    // classify the incoming request
    always_comb begin
        mapped  = (i_addr_hi == 64'd0) && (i_addr_lo[63:32] == csd_pkg::V4_MAP_WORD);
        cand_ok = (i_port != 16'd0)
                  && ((i_family == csd_pkg::FAM_V4) || (i_family == csd_pkg::FAM_V6))
                  && !((i_addr_hi == 64'd0) && (i_addr_lo == 64'd0))
                  && ((i_family == csd_pkg::FAM_V4) ? mapped : !mapped);
        cmd.rec = {i_family, i_addr_hi, i_addr_lo, i_port};
        if (i_action)     cmd.kind = csd_pkg::CMD_FIN;
        else if (cand_ok) cmd.kind = csd_pkg::CMD_ADD;
        else              cmd.kind = csd_pkg::CMD_BAD;
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_cmd_vld = (r_cnt != 2'd0);
    assign o_cmd     = r_q[r_rp];

    // queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cmd;
    end

endmodule

`default_nettype wire

### rtl/core/csd_back.sv
// ----------------------------------------------------------------------------
// csd_back: record store, sorted scan and message feed
// Stores records; on finish, repeated min-above-previous scans of the store
// emit records in order with duplicates skipped, byte by byte into SHA-256.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_back #(
    parameter int MAX_CANDIDATES = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cmd_vld,
    input  wire csd_pkg::t_cmd   i_cmd,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic [1:0]           o_status,
    output logic [255:0]         o_digest
);

    localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
    localparam int IDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int TOT_W = $clog2(MAX_CANDIDATES * csd_pkg::REC_BYTES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CANDIDATES);

    logic [csd_pkg::REC_W-1:0] r_mem [MAX_CANDIDATES];

    csd_pkg::t_state           r_state, n_state, r_ret, n_ret;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [1:0]                r_err, n_err;
    logic [CNT_W-1:0]          r_ridx, n_ridx;
    logic                      r_iss, n_iss;
    logic                      r_rvld, n_rvld;
    logic                      r_rlast, n_rlast;
    logic [csd_pkg::REC_W-1:0] r_rdata;
    logic                      r_found, n_found;
    logic [csd_pkg::REC_W-1:0] r_best, n_best;
    logic                      r_have_prev, n_have_prev;
    logic [csd_pkg::REC_W-1:0] r_prev, n_prev;
    logic [csd_pkg::REC_W-1:0] r_rec, n_rec;
    logic [4:0]                r_bcnt, n_bcnt;
    logic [5:0]                r_fill, n_fill;
    logic [511:0]              r_block, n_block;
    logic [TOT_W-1:0]          r_total, n_total;
    logic [63:0]               r_len, n_len;
    logic [3:0]                r_lcnt, n_lcnt;
    csd_pkg::t_sha_ctl         r_sha, n_sha;
    logic                      r_out_vld, n_out_vld;
    logic [1:0]                r_status, n_status;
    logic [255:0]              r_dig, n_dig;

    logic                      wr_en;
    logic                      rd_en;
    logic                      last_iss;
    logic                      take;
    logic                      feed;
    logic [7:0]                fbyte;
    csd_pkg::t_state           fnext;
    logic                      sha_busy;
    logic [255:0]              sha_hash;

    csd_sha u_sha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_sha),
        .i_block (r_block),
        .o_busy  (sha_busy),
        .o_hash  (sha_hash)
    );

    assign last_iss = (CNT_W'(r_ridx + 1'b1) == r_count);
    assign take     = (!r_have_prev || (r_rdata > r_prev)) && (!r_found || (r_rdata < r_best));

    // next state and outputs
    always_comb begin
        n_state = r_state;      n_ret = r_ret;
        n_count = r_count;      n_err = r_err;
        n_ridx = r_ridx;        n_iss = r_iss;
        n_rvld = 1'b0;          n_rlast = 1'b0;
        n_found = r_found;      n_best = r_best;
        n_have_prev = r_have_prev;
        n_prev = r_prev;        n_rec = r_rec;
        n_bcnt = r_bcnt;        n_fill = r_fill;
        n_block = r_block;      n_total = r_total;
        n_len = r_len;          n_lcnt = r_lcnt;
        n_sha = '0;
        n_out_vld = r_out_vld;  n_status = r_status;
        n_dig = r_dig;
        o_pop = 1'b0;
        wr_en = 1'b0;
        rd_en = 1'b0;
        feed  = 1'b0;
        fbyte = 8'h00;
        fnext = r_state;

        case (r_state)
            // take one request from the queue
            csd_pkg::S_IDLE: begin
                if (i_cmd_vld) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        csd_pkg::CMD_BAD: n_err = csd_pkg::ST_INVALID;
                        csd_pkg::CMD_ADD: begin
                            if (r_count == MAX_CNT) begin
                                if (r_err == csd_pkg::ST_OK) n_err = csd_pkg::ST_OVERFLOW;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        csd_pkg::CMD_FIN: begin
                            if (r_err != csd_pkg::ST_OK) begin
                                n_status  = r_err;
                                n_dig     = '0;
                                n_out_vld = 1'b1;
                                n_state   = csd_pkg::S_OUT;
                            end else begin
                                n_sha.init  = 1'b1;
                                n_have_prev = 1'b0;
                                n_fill      = '0;
                                n_total     = '0;
                                n_state     = csd_pkg::S_SCAN_START;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // begin one pass over the store
            csd_pkg::S_SCAN_START: begin
                if (r_count == '0) begin
                    n_state = csd_pkg::S_PAD_MARK;
                end else begin
                    n_ridx  = '0;
                    n_iss   = 1'b1;
                    n_found = 1'b0;
                    n_state = csd_pkg::S_SCAN;
                end
            end
            // find the smallest record above the last one emitted
            csd_pkg::S_SCAN: begin
                rd_en = r_iss;
                if (r_iss) begin
                    n_ridx = r_ridx + 1'b1;
                    if (last_iss) n_iss = 1'b0;
                end
                n_rvld  = rd_en;
                n_rlast = rd_en && last_iss;
                if (r_rvld) begin
                    if (take) begin
                        n_best  = r_rdata;
                        n_found = 1'b1;
                    end
                    if (r_rlast) begin
                        if (take || r_found) begin
                            n_rec       = take ? r_rdata : r_best;
                            n_prev      = take ? r_rdata : r_best;
                            n_have_prev = 1'b1;
                            n_bcnt      = 5'(csd_pkg::REC_BYTES);
                            n_state     = csd_pkg::S_FEED_REC;
                        end else begin
                            n_state = csd_pkg::S_PAD_MARK;
                        end
                    end
                end
            end
            // stream the record bytes
            csd_pkg::S_FEED_REC: begin
                feed    = 1'b1;
                fbyte   = r_rec[csd_pkg::REC_W-1 -: 8];
                n_rec   = r_rec << 8;
                n_bcnt  = r_bcnt - 5'd1;
                n_total = r_total + 1'b1;
                fnext   = (r_bcnt == 5'd1) ? csd_pkg::S_SCAN_START : csd_pkg::S_FEED_REC;
            end
            csd_pkg::S_PAD_MARK: begin
                feed   = 1'b1;
                fbyte  = csd_pkg::PAD_MARK;
                n_len  = 64'(r_total) << 3;
                n_lcnt = csd_pkg::LEN_BYTES;
                fnext  = csd_pkg::S_PAD_ZERO;
            end
            csd_pkg::S_PAD_ZERO: begin
                if (r_fill == csd_pkg::PAD_STOP) begin
                    n_state = csd_pkg::S_PAD_LEN;
                end else begin
                    feed  = 1'b1;
                    fbyte = 8'h00;
                    fnext = csd_pkg::S_PAD_ZERO;
                end
            end
            csd_pkg::S_PAD_LEN: begin
                feed   = 1'b1;
                fbyte  = r_len[63:56];
                n_len  = r_len << 8;
                n_lcnt = r_lcnt - 4'd1;
                fnext  = (r_lcnt == 4'd1) ? csd_pkg::S_DONE : csd_pkg::S_PAD_LEN;
            end
            // wait for the compressor
            csd_pkg::S_COMP: begin
                if (!r_sha.start && !sha_busy) n_state = r_ret;
            end
            csd_pkg::S_DONE: begin
                n_status  = csd_pkg::ST_OK;
                n_dig     = sha_hash;
                n_out_vld = 1'b1;
                n_state   = csd_pkg::S_OUT;
            end
            // hold the result, then start a new set
            csd_pkg::S_OUT: begin
                if (!i_out_stall) begin
                    n_out_vld = 1'b0;
                    n_count   = '0;
                    n_err     = csd_pkg::ST_OK;
                    n_state   = csd_pkg::S_IDLE;
                end
            end
            default: n_state = csd_pkg::S_IDLE;
        endcase

        // append one message byte, compress on a full block
        if (feed) begin
            n_block = {r_block[503:0], fbyte};
            n_fill  = r_fill + 6'd1;
            if (r_fill == 6'd63) begin
                n_sha.start = 1'b1;
                n_ret       = fnext;
                n_state     = csd_pkg::S_COMP;
            end else begin
                n_state = fnext;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= csd_pkg::S_IDLE;
            r_ret     <= csd_pkg::S_IDLE;
            r_count   <= '0;
            r_err     <= csd_pkg::ST_OK;
            r_iss     <= 1'b0;
            r_rvld    <= 1'b0;
            r_rlast   <= 1'b0;
            r_sha     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_count   <= n_count;
            r_err     <= n_err;
            r_iss     <= n_iss;
            r_rvld    <= n_rvld;
            r_rlast   <= n_rlast;
            r_sha     <= n_sha;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ridx      <= n_ridx;
        r_found     <= n_found;
        r_best      <= n_best;
        r_have_prev <= n_have_prev;
        r_prev      <= n_prev;
        r_rec       <= n_rec;
        r_bcnt      <= n_bcnt;
        r_fill      <= n_fill;
        r_block     <= n_block;
        r_total     <= n_total;
        r_len       <= n_len;
        r_lcnt      <= n_lcnt;
        r_status    <= n_status;
        r_dig       <= n_dig;
    end

    // record store
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_count[IDX_W-1:0]] <= i_cmd.rec;
        if (rd_en) r_rdata <= r_mem[r_ridx[IDX_W-1:0]];
    end

    assign o_out_valid = r_out_vld;
    assign o_status    = r_status;
    assign o_digest    = r_dig;

endmodule

`default_nettype wire

### rtl/core/candidate_set_sort_dedup_sha256_unit.sv
// ----------------------------------------------------------------------------
// candidate_set_sort_dedup_sha256_unit: sorted candidate set digest
// Collects endpoint candidates and, on finish, returns the SHA-256 of the
// sorted, deduplicated record list, or an error status.
// ----------------------------------------------------------------------------
//   channel   handshake                  payload
//   input     i_in_valid / o_in_stall    action, family, address, port
//   output    o_out_valid / i_out_stall  status, digest words 0..3
//
// The back end takes an add request in its idle state; a two-entry queue lets
// the front accept while the back end works. A finish with U unique records
// out of N > 0 stored scans the store U+1 times, feeds the 19 bytes of each
// unique record and the pad bytes, and compresses each full 64-byte block.
// Reset is synchronous and active low; the store needs no clearing.
// A stalled result is held; new requests queue up behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module candidate_set_sort_dedup_sha256_unit #(
    parameter int MAX_CANDIDATES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_action,
    input  wire logic [7:0]  i_candidate_family,
    input  wire logic [63:0] i_address_upper,
    input  wire logic [63:0] i_address_lower,
    input  wire logic [15:0] i_endpoint_port,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [63:0]      o_digest_word0,
    output logic [63:0]      o_digest_word1,
    output logic [63:0]      o_digest_word2,
    output logic [63:0]      o_digest_word3
);

    logic          cmd_vld;
    csd_pkg::t_cmd cmd;
    logic          pop;
    logic [255:0]  digest;

    csd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_action  (i_action),
        .i_family  (i_candidate_family),
        .i_addr_hi (i_address_upper),
        .i_addr_lo (i_address_lower),
        .i_port    (i_endpoint_port),
        .o_cmd_vld (cmd_vld),
        .o_cmd     (cmd),
        .i_pop     (pop)
    );

    csd_back #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_vld   (cmd_vld),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_digest    (digest)
    );

    assign o_digest_word0 = digest[255:192];
    assign o_digest_word1 = digest[191:128];
    assign o_digest_word2 = digest[127:64];
    assign o_digest_word3 = digest[63:0];

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != csd_pkg::ST_OK) |->
        (digest == 256'd0))
        else $error("error result carries a nonzero digest");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != 2'd3))
        else $error("result status out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result or stall present after reset");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: candidate set sort, dedup and SHA-256 unit
// Drives add and finish requests under several idle and stall phases, predicts
// each finish result (sort, dedup, SHA-256 or error status) and checks every
// result field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int CAP       = 64;
    localparam int IDLE_LIM  = 200000;
    localparam bit ACT_ADD   = 1'b0;
    localparam bit ACT_FIN   = 1'b1;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] d0;
        logic [63:0] d1;
        logic [63:0] d2;
        logic [63:0] d3;
    } t_digest_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_action = 1'b0;
    logic [7:0]  i_candidate_family = '0;
    logic [63:0] i_address_upper = '0;
    logic [63:0] i_address_lower = '0;
    logic [15:0] i_endpoint_port = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [63:0] o_digest_word0, o_digest_word1, o_digest_word2, o_digest_word3;

    // predictor state
    logic [151:0] set_recs[CAP];
    int           set_count;
    logic [1:0]   set_err;
    t_digest_res  digest_q[$];

    int  err_count;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_recv;
    int  hold_cycles;

    candidate_set_sort_dedup_sha256_unit #(.MAX_CANDIDATES(CAP)) u_dut (.*);

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------ predictor
    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic bit cand_valid(logic [7:0] fam, logic [63:0] hi, logic [63:0] lo,
                                      logic [15:0] port);
        bit mapped;
        if (port == 0 || (fam != csd_pkg::FAM_V4 && fam != csd_pkg::FAM_V6)) return 0;
        if (hi == 0 && lo == 0) return 0;
        mapped = (hi == 0) && (lo[63:32] == csd_pkg::V4_MAP_WORD);
        return (fam == csd_pkg::FAM_V4) ? mapped : !mapped;
    endfunction

    function automatic t_digest_res hash_set();
        logic [151:0] srt[$];
        logic [7:0]   msg[$];
        logic [31:0]  h[8], w[64], v[8], t1, t2, s0, s1;
        logic [63:0]  nbits;
        t_digest_res  r;
        logic [151:0] tmp;
        for (int i = 0; i < set_count; i++) srt.push_back(set_recs[i]);
        // family is the top byte, port the low bytes: vector compare is byte order
        for (int i = 1; i < srt.size(); i++)
            for (int j = i; j > 0 && srt[j-1] > srt[j]; j--) begin
                tmp = srt[j]; srt[j] = srt[j-1]; srt[j-1] = tmp;
            end
        for (int i = 0; i < srt.size(); i++) begin
            if (i > 0 && srt[i] == srt[i-1]) continue;
            for (int b = 18; b >= 0; b--) msg.push_back(srt[i][b*8 +: 8]);
        end
        nbits = 64'(msg.size()) << 3;
        msg.push_back(csd_pkg::PAD_MARK);
        while (msg.size() % 64 != 56) msg.push_back(8'h00);
        for (int b = 7; b >= 0; b--) msg.push_back(nbits[b*8 +: 8]);
        for (int i = 0; i < 8; i++) h[i] = csd_pkg::SHA_IV[i];
        for (int blk = 0; blk < msg.size() / 64; blk++) begin
            for (int i = 0; i < 16; i++)
                w[i] = {msg[blk*64+4*i], msg[blk*64+4*i+1], msg[blk*64+4*i+2],
                        msg[blk*64+4*i+3]};
            for (int i = 16; i < 64; i++) begin
                s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            for (int i = 0; i < 8; i++) v[i] = h[i];
            for (int i = 0; i < 64; i++) begin
                t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + csd_pkg::sha_k(6'(i)) + w[i];
                t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) h[i] += v[i];
        end
        r.status = csd_pkg::ST_OK;
        r.d0 = {h[0], h[1]}; r.d1 = {h[2], h[3]};
        r.d2 = {h[4], h[5]}; r.d3 = {h[6], h[7]};
        return r;
    endfunction

    function automatic void predict(bit act, logic [7:0] fam, logic [63:0] hi,
                                    logic [63:0] lo, logic [15:0] port);
        t_digest_res r;
        if (act == ACT_ADD) begin
            if (!cand_valid(fam, hi, lo, port)) set_err = csd_pkg::ST_INVALID;
            else if (set_count >= CAP) begin
                if (set_err == csd_pkg::ST_OK) set_err = csd_pkg::ST_OVERFLOW;
            end else begin
                set_recs[set_count] = {fam, hi, lo, port};
                set_count++;
            end
            return;
        end
        if (set_err != csd_pkg::ST_OK) r = '{status: set_err, default: '0};
        else r = hash_set();
        digest_q.push_back(r);
        set_count = 0;
        set_err = csd_pkg::ST_OK;
    endfunction

    // ------------------------------------------------------------------ driver
    // called at a falling edge; returns at the falling edge after acceptance with
    // valid still high, so the next call or an idle phase takes the bus over
    task automatic send_req(bit act, logic [7:0] fam, logic [63:0] hi, logic [63:0] lo,
                            logic [15:0] port);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_candidate_family <= fam;
        i_address_upper <= hi;
        i_address_lower <= lo;
        i_endpoint_port <= port;
        // wait for acceptance at a rising edge
        do @(posedge i_clk); while (o_in_stall);
        predict(act, fam, hi, lo, port);
        @(negedge i_clk);
    endtask

    task automatic send_finish();
        send_req(ACT_FIN, 8'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                 16'($urandom));
    endtask

    // valid random candidate; small pool so duplicates and sort work show up
    task automatic send_good(bit dup_pool);
        logic [63:0] hi, lo;
        logic [7:0]  fam;
        logic [15:0] port;
        port = dup_pool ? 16'($urandom_range(1, 3)) : 16'($urandom_range(1, 65535));
        if ($urandom_range(1)) begin
            fam = csd_pkg::FAM_V4;
            hi = '0;
            lo = {csd_pkg::V4_MAP_WORD, dup_pool ? 32'($urandom_range(0, 3)) : 32'($urandom)};
        end else begin
            fam = csd_pkg::FAM_V6;
            hi = dup_pool ? 64'($urandom_range(0, 2)) << 56 : {$urandom, $urandom};
            lo = dup_pool ? 64'($urandom_range(1, 3)) : {$urandom, $urandom};
            if (hi == 0 && lo[63:32] == csd_pkg::V4_MAP_WORD) lo[63] = 1'b1;
        end
        send_req(ACT_ADD, fam, hi, lo, port);
    endtask

    // broken candidate of one of several kinds
    task automatic send_bad();
        logic [63:0] hi, lo;
        logic [7:0]  fam;
        logic [15:0] port;
        fam = $urandom_range(1) ? csd_pkg::FAM_V4 : csd_pkg::FAM_V6;
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
        port = 16'($urandom_range(1, 65535));
        case ($urandom_range(4))
            0: port = '0;
            1: begin
                fam = 8'($urandom);
                if (fam == csd_pkg::FAM_V4 || fam == csd_pkg::FAM_V6) fam = 8'hff;
            end
            2: begin hi = '0; lo = '0; end
            3: begin fam = csd_pkg::FAM_V4; hi[0] = 1'b1; end
            default: begin
                fam = csd_pkg::FAM_V6; hi = '0; lo[63:32] = csd_pkg::V4_MAP_WORD;
            end
        endcase
        send_req(ACT_ADD, fam, hi, lo, port);
    endtask

    // drop valid and hold until every predicted result has come out
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (digest_q.size() != 0) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------ tests
    task automatic test_directed();
        // empty set
        send_finish();
        // field extremes, valid
        send_req(ACT_ADD, csd_pkg::FAM_V6, '1, '1, 16'hffff);
        send_req(ACT_ADD, csd_pkg::FAM_V6, 64'h0, 64'h1, 16'h0001);
        send_req(ACT_ADD, csd_pkg::FAM_V4, 64'h0, {csd_pkg::V4_MAP_WORD, 32'h0}, 16'h0001);
        send_req(ACT_ADD, csd_pkg::FAM_V4, 64'h0, {csd_pkg::V4_MAP_WORD, 32'hffffffff},
                 16'hffff);
        send_req(ACT_ADD, csd_pkg::FAM_V6, '1, '1, 16'hffff);
        send_finish();
        // each invalid kind, each followed by a finish
        send_req(ACT_ADD, csd_pkg::FAM_V6, '1, '1, 16'h0000);
        send_finish();
        send_req(ACT_ADD, 8'hff, '1, '1, 16'hffff);
        send_req(ACT_ADD, 8'h00, '1, '1, 16'hffff);
        send_finish();
        send_req(ACT_ADD, csd_pkg::FAM_V6, '0, '0, 16'h1234);
        send_finish();
        send_req(ACT_ADD, csd_pkg::FAM_V4, 64'h1, {csd_pkg::V4_MAP_WORD, 32'h0}, 16'h1);
        send_finish();
        send_req(ACT_ADD, csd_pkg::FAM_V6, 64'h0, {csd_pkg::V4_MAP_WORD, 32'h01020304},
                 16'h1);
        send_finish();
    endtask

    task automatic test_overflow();
        // fill, overflow, then invalid takes priority
        for (int i = 0; i < CAP + 2; i++) send_good(1'b0);
        send_finish();
        for (int i = 0; i < CAP + 1; i++) send_good(1'b1);
        send_bad();
        send_finish();
        // exactly full
        for (int i = 0; i < CAP; i++) send_good(1'b1);
        send_finish();
    endtask

    task automatic test_random(int n_sets);
        int n;
        for (int s = 0; s < n_sets; s++) begin
            n = $urandom_range(9) == 0 ? $urandom_range(CAP - 4, CAP + 2)
                                       : $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(29) == 0) send_bad();
                else send_good($urandom_range(1));
            end
            send_finish();
        end
    endtask

    task automatic test_backpressure();
        // receiver holds off long while the sender keeps offering requests
        hold_cycles = 400;
        hold_recv = 1'b1;
        for (int i = 0; i < 4; i++) begin
            send_good(1'b1);
            send_finish();
        end
        wait_drain();
    endtask

    // ------------------------------------------------------------------ checker
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (digest_q.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_status), 64'h0);
            end else begin
                t_digest_res w;
                w = digest_q.pop_front();
                if (o_status !== w.status) report_mismatch("status", 64'(o_status), 64'(w.status));
                if (o_digest_word0 !== w.d0) report_mismatch("digest0", o_digest_word0, w.d0);
                if (o_digest_word1 !== w.d1) report_mismatch("digest1", o_digest_word1, w.d1);
                if (o_digest_word2 !== w.d2) report_mismatch("digest2", o_digest_word2, w.d2);
                if (o_digest_word3 !== w.d3) report_mismatch("digest3", o_digest_word3, w.d3);
            end
        end
    end

    // receiver stall, with a long counted hold-off on request
    always @(negedge i_clk) begin
        if (hold_recv) begin
            i_out_stall <= 1'b1;
            if (hold_cycles == 0) hold_recv <= 1'b0;
            else hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles with no acceptance on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIM) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        set_count = 0;
        set_err = csd_pkg::ST_OK;
        err_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 1'b0;
        hold_cycles = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_overflow();
        test_random(8);
        send_idle_pct = 50;
        test_random(8);
        wait_drain();
        send_idle_pct = 0;
        recv_stall_pct = 50;
        test_random(8);
        send_idle_pct = 16;
        recv_stall_pct = 16;
        test_random(8);
        recv_stall_pct = 0;
        send_idle_pct = 0;
        test_backpressure();

        wait_drain();
        repeat (50) @(negedge i_clk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/csd_pkg.sv
rtl/core/csd_sha.sv
rtl/core/csd_front.sv
rtl/core/csd_back.sv
rtl/core/candidate_set_sort_dedup_sha256_unit.sv
tb/testbench.sv
